// File: hw/rtl/fmbq_pkg.sv
// Package for the front/middle/back queue.
// Holds the operation codes and the per-cell shift modes shared by the
// cell row and the top level. No dependencies.
package fmbq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 3;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_PUSH_MIDDLE = 3'd1,
    OP_PUSH_BACK   = 3'd2,
    OP_POP_FRONT   = 3'd3,
    OP_POP_MIDDLE  = 3'd4,
    OP_POP_BACK    = 3'd5
  } op_e;

  // What a cell does on the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_TAKE_LEFT  = 2'd2,
    CELL_TAKE_RIGHT = 2'd3
  } cell_mode_e;

endpackage

// File: hw/rtl/fmbq_cell.sv
// One storage cell of the queue row.
// Holds a single entry and loads it from the new value or from either
// neighbour. Depends on fmbq_pkg.
module fmbq_cell
  import fmbq_pkg::*;
(
  input  logic             clk_i,
  input  cell_mode_e       mode_i,
  input  logic [DataW-1:0] value_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  output logic [DataW-1:0] data_o
);

  logic [DataW-1:0] data_d, data_q;

  always_comb begin
    case (mode_i)
      CELL_LOAD:       data_d = value_i;
      CELL_TAKE_LEFT:  data_d = left_i;
      CELL_TAKE_RIGHT: data_d = right_i;
      default:         data_d = data_q;
    endcase
  end

  // Payload only: no reset needed.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: hw/rtl/front_middle_back_queue.sv
// Front/middle/back queue of signed 32-bit values.
// Top level: occupancy count, position decode, cell row and result register.
// Depends on fmbq_pkg and fmbq_cell.
//
// Usage:
//   Input channel s_axis: tuser carries the operation (push front, middle,
//   back; pop front, middle, back), tdata the value to push. Output channel
//   m_axis: one result transaction per input transaction, tdata the popped
//   value (-1 on an empty pop, 0 on pushes), tuser the empty and full flags.
//   A middle push inserts at floor(count/2); a middle pop takes the element
//   at ceil(count/2)-1. A push on a full store is dropped and flagged.
//   The result appears in the output register on the edge after the input
//   transaction. One operation is taken per cycle unless the receiver stalls:
//   the whole row of DEPTH cells shifts at once, moved entries coming from
//   a neighbour, and the popped entry is picked from the row in that cycle.
//   The output register frees the input side, so a new input transaction is
//   taken whenever the result register is empty or is being drained.
//   When the receiver stalls, the result holds and input is refused.
//   Reset empties the queue and the output register; stored entries keep
//   whatever they held and are never read before being written.
module front_middle_back_queue
  import fmbq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] popped_value
  output logic [1:0]  m_axis_tuser_o    // [0] empty_error, [1] full_error
);

  localparam int unsigned OccW = $clog2(DEPTH + 1);
  localparam int unsigned PosW = $clog2(DEPTH);

  logic [OccW-1:0] occ_d, occ_q;
  logic            accept;
  logic            is_push, is_pop;
  logic            q_full, q_empty;
  logic [OccW-1:0] pos_wide;
  logic [PosW-1:0] pos;
  logic            do_ins, do_rem;

  logic [DataW-1:0] cell_data [DEPTH];
  cell_mode_e       cell_mode [DEPTH];
  logic [DataW-1:0] read_data;

  logic             out_valid_q;
  logic [DataW-1:0] out_data_d, out_data_q;
  logic             out_empty_d, out_empty_q;
  logic             out_full_d, out_full_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign q_full  = (occ_q == OccW'(DEPTH));
  assign q_empty = (occ_q == '0);

  // Decode the operation and the affected position.
  always_comb begin
    is_push  = 1'b0;
    is_pop   = 1'b0;
    pos_wide = '0;
    case (op_e'(s_axis_tuser_i))
      OP_PUSH_FRONT: begin
        is_push = 1'b1;
      end
      OP_PUSH_MIDDLE: begin
        is_push  = 1'b1;
        pos_wide = occ_q >> 1;
      end
      OP_PUSH_BACK: begin
        is_push  = 1'b1;
        pos_wide = occ_q;
      end
      OP_POP_FRONT: begin
        is_pop = 1'b1;
      end
      OP_POP_MIDDLE: begin
        is_pop   = 1'b1;
        pos_wide = (occ_q - OccW'(1)) >> 1;
      end
      OP_POP_BACK: begin
        is_pop   = 1'b1;
        pos_wide = occ_q - OccW'(1);
      end
      default: begin
        is_push = 1'b0;
      end
    endcase
  end

  assign pos    = pos_wide[PosW-1:0];
  assign do_ins = accept && is_push && !q_full;
  assign do_rem = accept && is_pop && !q_empty;

  always_comb begin
    occ_d = occ_q;
    if (do_ins) begin
      occ_d = occ_q + OccW'(1);
    end else if (do_rem) begin
      occ_d = occ_q - OccW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Cell row: insert shifts towards the back, remove towards the front.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [PosW-1:0] Idx = PosW'(i);
    logic [DataW-1:0] left, right;

    always_comb begin
      if (do_ins && Idx > pos) begin
        cell_mode[i] = CELL_TAKE_LEFT;
      end else if (do_ins && Idx == pos) begin
        cell_mode[i] = CELL_LOAD;
      end else if (do_rem && Idx >= pos) begin
        cell_mode[i] = CELL_TAKE_RIGHT;
      end else begin
        cell_mode[i] = CELL_HOLD;
      end
    end

    if (i == 0) begin : g_first
      assign left = cell_data[i];
    end else begin : g_inner_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_inner_r
      assign right = cell_data[i+1];
    end

    fmbq_cell u_cell (
      .clk_i   (clk_i),
      .mode_i  (cell_mode[i]),
      .value_i (s_axis_tdata_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

  // Pick the entry at the pop position.
  always_comb begin
    read_data = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (PosW'(i) == pos) begin
        read_data = read_data | cell_data[i];
      end
    end
  end

  always_comb begin
    out_data_d  = '0;
    out_empty_d = 1'b0;
    out_full_d  = 1'b0;
    if (is_push) begin
      out_full_d = q_full;
    end else if (is_pop) begin
      if (q_empty) begin
        out_data_d  = '1;
        out_empty_d = 1'b1;
      end else begin
        out_data_d = read_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q  <= out_data_d;
      out_empty_q <= out_empty_d;
      out_full_q  <= out_full_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = {out_full_q, out_empty_q};

endmodule

// File: hw/rtl/fmbq_chk.sv
// Port-level checker for the front/middle/back queue.
// Watches the top-level channels only; attached by the bind at the end.
// No package dependencies.
module fmbq_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Every input transaction yields a result on the next edge.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("no result after input transaction");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("empty and full flagged together");

  a_empty_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == 32'hFFFF_FFFF)
    else $error("empty pop did not return -1");

  a_full_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tdata_o == 32'h0)
    else $error("dropped push returned data");

endmodule

bind front_middle_back_queue fmbq_chk u_fmbq_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
